FILE: src/line_intersection_point_macros.svh
// Assertion macros for the line intersection point checker.
// Depends on nothing; the asserting file provides aclk and aresetn.
`ifndef LINE_INTERSECTION_POINT_MACROS_SVH
`define LINE_INTERSECTION_POINT_MACROS_SVH

// Concurrent check, clocked on aclk, quiet while reset is held.
`define LIP_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: property failed");

// Concurrent check that also runs through reset.
`define LIP_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("%m: property failed");

`endif

FILE: src/lip_pkg.sv
// Shared constants, status codes and control struct for the intersection block.
// Depends on nothing.
`default_nettype none
package lip_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIELD_BITS     = 16;
    localparam int OUT_BITS       = 48;
    // Quotient bits resolved by the divider chain, one per cell.
    localparam int QB             = OUT_BITS + 1;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    typedef struct packed {
        logic det_zero;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } lip_ctrl_t;
endpackage
`default_nettype wire

FILE: src/line_intersection_point.sv
// Line intersection point, top level: front end, divider cell chain, rounding.
// Depends on lip_pkg, lip_front and lip_div_cell.
//
// Usage:
//   s_ channel: one beat carries two lines as eight signed coordinates.
//   m_ channel: one beat carries status in m_tuser and the crossing point
//   in m_tdata as signed fixed point with FRAC_BITS fraction bits.
//   Throughput: one beat per cycle while m_tready does not stall the output.
//   Pipeline: four front-end stages, one cell per quotient bit (49 cells),
//   and one output register.
//   Each cell owns one quotient bit of both divisions and passes the
//   partial remainder to its neighbor whenever the pipeline advances.
//   Reset: aresetn low clears all valid flags; the pipeline comes up empty
//   and s_tready is high at once.
//   Stall: while a result beat waits with m_tready low, the whole pipeline
//   holds and s_tready drops; nothing in flight is lost or repeated.
//   Parallel or coincident lines give status 1 and a zero point; a
//   coordinate out of the 48-bit range saturates and gives status 2.
`default_nettype none
module line_intersection_point #(
    parameter int COORD_BITS = lip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lip_pkg::FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // ax, ay, bx, by_coord, cx, cy, dx, dy (16 bits each, low first)
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cross_x [47:0], cross_y [95:48]
    output logic [95:0]       m_tdata,
    // status [1:0]
    output logic [1:0]        m_tuser
);
    import lip_pkg::*;

    localparam int DW = 2 * COORD_BITS + 3;

    logic            en;
    logic            v_c   [0:QB];
    lip_ctrl_t       ctl_c [0:QB];
    logic [DW-1:0]   d_c   [0:QB];
    logic [DW-1:0]   rx_c  [0:QB];
    logic [DW-1:0]   ry_c  [0:QB];
    logic [QB-1:0]   wx_c  [0:QB];
    logic [QB-1:0]   wy_c  [0:QB];

    logic [OUT_BITS:0] fx, fy;
    logic [1:0]        status_next;
    logic [95:0]       data_next;
    logic              m_tvalid_reg;

    // advance whenever the output register is free or being drained
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    lip_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .out_valid  (v_c[0]),
        .out_ctrl   (ctl_c[0]),
        .out_d      (d_c[0]),
        .out_rem_x  (rx_c[0]),
        .out_word_x (wx_c[0]),
        .out_rem_y  (ry_c[0]),
        .out_word_y (wy_c[0])
    );

    for (genvar i = 0; i < QB; i++) begin : g_cell
        lip_div_cell #(
            .DW (DW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .in_valid   (v_c[i]),
            .in_ctrl    (ctl_c[i]),
            .in_d       (d_c[i]),
            .in_rem_x   (rx_c[i]),
            .in_word_x  (wx_c[i]),
            .in_rem_y   (ry_c[i]),
            .in_word_y  (wy_c[i]),
            .out_valid  (v_c[i+1]),
            .out_ctrl   (ctl_c[i+1]),
            .out_d      (d_c[i+1]),
            .out_rem_x  (rx_c[i+1]),
            .out_word_x (wx_c[i+1]),
            .out_rem_y  (ry_c[i+1]),
            .out_word_y (wy_c[i+1])
        );
    end

    // round half away from zero, clamp, apply sign; top bit flags saturation
    function automatic logic [OUT_BITS:0] finish(input logic [QB-1:0] q,
                                                 input logic [DW-1:0] rem,
                                                 input logic [DW-1:0] d,
                                                 input logic ovf,
                                                 input logic neg);
        logic          up;
        logic [QB:0]   mag;
        logic [QB:0]   lim;
        logic [QB:0]   m;
        logic [QB:0]   v;
        logic          sat;
        up  = ({rem, 1'b0} >= {1'b0, d});
        mag = (QB + 1)'(q) + (QB + 1)'(up);
        lim = ((QB + 1)'(1) << (OUT_BITS - 1)) - (QB + 1)'(!neg);
        sat = ovf || (mag > lim);
        m   = sat ? lim : mag;
        v   = neg ? -m : m;
        return {sat, v[OUT_BITS-1:0]};
    endfunction

    assign fx = finish(wx_c[QB], rx_c[QB], d_c[QB], ctl_c[QB].ovf_x, ctl_c[QB].neg_x);
    assign fy = finish(wy_c[QB], ry_c[QB], d_c[QB], ctl_c[QB].ovf_y, ctl_c[QB].neg_y);

    always_comb begin
        if (ctl_c[QB].det_zero) begin
            status_next = ST_PARALLEL;
            data_next   = '0;
        end else begin
            status_next = (fx[OUT_BITS] || fy[OUT_BITS]) ? ST_SAT : ST_FOUND;
            data_next   = {fy[OUT_BITS-1:0], fx[OUT_BITS-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= data_next;
            m_tuser <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v_c[QB];
        end
    end

    assign m_tvalid = m_tvalid_reg;
endmodule
`default_nettype wire

FILE: src/lip_front.sv
// Front end: line coefficients, determinant, numerators and divider setup.
// Four register stages. Depends on lip_pkg.
`default_nettype none
module lip_front #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [8*lip_pkg::FIELD_BITS-1:0] in_data,
    output logic                           out_valid,
    output lip_pkg::lip_ctrl_t             out_ctrl,
    output logic [2*COORD_BITS+2:0]        out_d,
    output logic [2*COORD_BITS+2:0]        out_rem_x,
    output logic [lip_pkg::QB-1:0]         out_word_x,
    output logic [2*COORD_BITS+2:0]        out_rem_y,
    output logic [lip_pkg::QB-1:0]         out_word_y
);
    import lip_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int AW   = C + 1;
    localparam int CW   = 2 * C + 2;
    localparam int DW   = 2 * C + 3;
    localparam int PW   = 3 * C + 3;
    localparam int NW   = 3 * C + 4;
    localparam int NTW  = (NW + FRAC_BITS > QB) ? NW + FRAC_BITS : QB + 1;
    localparam int HW   = NTW - QB;
    localparam int CMPW = (HW > DW) ? HW : DW;

    // stage 1
    logic signed [C-1:0]  x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [C-1:0]  x1_reg, y1_reg, x3_reg, y3_reg;
    logic signed [AW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic                 v1_reg;
    // stage 2
    logic signed [2*C:0]  p1, p2, p3, p4;
    logic signed [DW-1:0] q1, q2;
    logic signed [CW-1:0] c1_next, c2_next, c1_reg, c2_reg;
    logic signed [DW-1:0] det_next, det2_reg;
    logic signed [AW-1:0] a1b_reg, b1b_reg, a2b_reg, b2b_reg;
    logic                 v2_reg;
    // stage 3
    logic signed [PW-1:0] m1, m2, m3, m4;
    logic signed [NW-1:0] nx_next, ny_next, nx_reg, ny_reg;
    logic signed [DW-1:0] det3_reg;
    logic                 v3_reg;
    // stage 4
    logic [NW-1:0]   absx, absy;
    logic [DW-1:0]   absd;
    logic [NTW-1:0]  shx, shy;
    logic [CMPW-1:0] topx, topy, dz;
    logic            negd;
    lip_ctrl_t       ctrl_next;

    assign x1 = $signed(in_data[0*FIELD_BITS +: C]);
    assign y1 = $signed(in_data[1*FIELD_BITS +: C]);
    assign x2 = $signed(in_data[2*FIELD_BITS +: C]);
    assign y2 = $signed(in_data[3*FIELD_BITS +: C]);
    assign x3 = $signed(in_data[4*FIELD_BITS +: C]);
    assign y3 = $signed(in_data[5*FIELD_BITS +: C]);
    assign x4 = $signed(in_data[6*FIELD_BITS +: C]);
    assign y4 = $signed(in_data[7*FIELD_BITS +: C]);

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= x1;
            y1_reg <= y1;
            x3_reg <= x3;
            y3_reg <= y3;
            a1_reg <= AW'(y2) - AW'(y1);
            b1_reg <= AW'(x1) - AW'(x2);
            a2_reg <= AW'(y4) - AW'(y3);
            b2_reg <= AW'(x3) - AW'(x4);
        end
    end

    assign p1       = a1_reg * x1_reg;
    assign p2       = b1_reg * y1_reg;
    assign p3       = a2_reg * x3_reg;
    assign p4       = b2_reg * y3_reg;
    assign c1_next  = CW'(p1) + CW'(p2);
    assign c2_next  = CW'(p3) + CW'(p4);
    assign q1       = DW'(a1_reg * b2_reg);
    assign q2       = DW'(a2_reg * b1_reg);
    assign det_next = q1 - q2;

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            det2_reg <= det_next;
            a1b_reg  <= a1_reg;
            b1b_reg  <= b1_reg;
            a2b_reg  <= a2_reg;
            b2b_reg  <= b2_reg;
        end
    end

    assign m1      = b2b_reg * c1_reg;
    assign m2      = b1b_reg * c2_reg;
    assign m3      = a1b_reg * c2_reg;
    assign m4      = a2b_reg * c1_reg;
    assign nx_next = NW'(m1) - NW'(m2);
    assign ny_next = NW'(m3) - NW'(m4);

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            det3_reg <= det2_reg;
        end
    end

    assign negd = det3_reg[DW-1];
    assign absx = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
    assign absy = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
    assign absd = negd ? DW'(-det3_reg) : DW'(det3_reg);
    assign shx  = NTW'(absx) << FRAC_BITS;
    assign shy  = NTW'(absy) << FRAC_BITS;
    assign topx = CMPW'(shx[NTW-1:QB]);
    assign topy = CMPW'(shy[NTW-1:QB]);
    assign dz   = CMPW'(absd);

    always_comb begin
        ctrl_next.det_zero = (det3_reg == '0);
        ctrl_next.neg_x    = nx_reg[NW-1] ^ negd;
        ctrl_next.neg_y    = ny_reg[NW-1] ^ negd;
        // quotient too wide for the chain: saturate
        ctrl_next.ovf_x    = (topx >= dz);
        ctrl_next.ovf_y    = (topy >= dz);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctrl   <= ctrl_next;
            out_d      <= absd;
            out_rem_x  <= topx[DW-1:0];
            out_rem_y  <= topy[DW-1:0];
            out_word_x <= shx[QB-1:0];
            out_word_y <= shy[QB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else if (en) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_valid <= v3_reg;
        end
    end
endmodule
`default_nettype wire

FILE: src/lip_div_cell.sv
// One restoring-division cell: resolves one quotient bit for both lanes.
// Depends on lip_pkg.
`default_nettype none
module lip_div_cell #(
    parameter int DW = 35
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire lip_pkg::lip_ctrl_t in_ctrl,
    input  wire logic [DW-1:0]      in_d,
    input  wire logic [DW-1:0]      in_rem_x,
    input  wire logic [lip_pkg::QB-1:0] in_word_x,
    input  wire logic [DW-1:0]      in_rem_y,
    input  wire logic [lip_pkg::QB-1:0] in_word_y,
    output logic                    out_valid,
    output lip_pkg::lip_ctrl_t      out_ctrl,
    output logic [DW-1:0]           out_d,
    output logic [DW-1:0]           out_rem_x,
    output logic [lip_pkg::QB-1:0]  out_word_x,
    output logic [DW-1:0]           out_rem_y,
    output logic [lip_pkg::QB-1:0]  out_word_y
);
    import lip_pkg::*;

    // word: numerator bits shift out the top, quotient bits shift in below
    function automatic logic [DW+QB-1:0] step(input logic [DW-1:0] rem,
                                              input logic [QB-1:0] word,
                                              input logic [DW-1:0] d);
        logic [DW:0] t;
        logic [DW:0] diff;
        logic        qbit;
        t    = {rem, word[QB-1]};
        diff = t - {1'b0, d};
        qbit = (t >= {1'b0, d});
        return {qbit ? diff[DW-1:0] : t[DW-1:0], word[QB-2:0], qbit};
    endfunction

    logic [DW+QB-1:0] sx, sy;

    assign sx = step(in_rem_x, in_word_x, in_d);
    assign sy = step(in_rem_y, in_word_y, in_d);

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctrl   <= in_ctrl;
            out_d      <= in_d;
            out_rem_x  <= sx[DW+QB-1:QB];
            out_word_x <= sx[QB-1:0];
            out_rem_y  <= sy[DW+QB-1:QB];
            out_word_y <= sy[QB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end
endmodule
`default_nettype wire

FILE: src/lip_checker.sv
// Port-level checks for line_intersection_point, attached by bind.
// Depends on lip_pkg and line_intersection_point_macros.svh.
`default_nettype none
`include "line_intersection_point_macros.svh"
module lip_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [95:0]  m_tdata,
    input wire logic [1:0]   m_tuser
);
    import lip_pkg::*;

    // hold a stalled result beat
    `LIP_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // an empty output stage never blocks the input
    `LIP_ASSERT(a_ready, !m_tvalid |-> s_tready)
    // parallel lines carry a zero point
    `LIP_ASSERT(a_par, m_tvalid && m_tuser == ST_PARALLEL |-> m_tdata == '0)
    // only the three defined status codes leave the block
    `LIP_ASSERT(a_code, m_tvalid |-> m_tuser == ST_FOUND || m_tuser == ST_PARALLEL || m_tuser == ST_SAT)
    // reset empties the output stage
    `LIP_ASSERT_RST(a_rst, !aresetn |=> !m_tvalid)
endmodule

bind line_intersection_point lip_checker u_lip_checker (.*);
`default_nettype wire

FILE: sim/testbench.sv
// Testbench for line_intersection_point: random and directed line pairs,
// predicted in-line and checked beat by beat. Depends on lip_pkg and the RTL.
`timescale 1ns / 100ps
module testbench;
    import lip_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;

    typedef struct {
        logic [1:0]  status;
        logic [47:0] cx;
        logic [47:0] cy;
    } cross_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    logic [127:0] pending_pairs[$];
    cross_t       expected_points[$];
    int           errors = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    line_intersection_point dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // Fixed-point quotient with round half away from zero; returns 1 on saturation.
    function automatic bit fixed_quotient(longint num, longint den, output logic [47:0] res);
        bit          neg;
        logic [63:0] n, d, q, r, t, f, mag, lim, lim_neg;
        bit          sat;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        lim_neg = 64'd1 << 47;
        lim = neg ? lim_neg : lim_neg - 1;
        q = n / d;
        r = n % d;
        sat = 0;
        if (q > (lim_neg >> FB)) begin
            mag = lim;
            sat = 1;
        end else begin
            t = r << FB;
            f = t / d;
            if (2 * (t % d) >= d) f++;
            mag = (q << FB) + f;
            if (mag > lim) begin
                mag = lim;
                sat = 1;
            end
        end
        if (neg) mag = -mag;
        res = mag[47:0];
        return sat;
    endfunction

    function automatic cross_t predict_crossing(logic [127:0] pair);
        longint p[8];
        longint a1, b1, c1, a2, b2, c2, det;
        cross_t e;
        bit     sx, sy;
        for (int i = 0; i < 8; i++) p[i] = longint'($signed(pair[i*16 +: CB]));
        a1 = p[3] - p[1];
        b1 = p[0] - p[2];
        c1 = a1 * p[0] + b1 * p[1];
        a2 = p[7] - p[5];
        b2 = p[4] - p[6];
        c2 = a2 * p[4] + b2 * p[5];
        det = a1 * b2 - a2 * b1;
        if (det == 0) begin
            e.status = ST_PARALLEL;
            e.cx = '0;
            e.cy = '0;
        end else begin
            sx = fixed_quotient(b2 * c1 - b1 * c2, det, e.cx);
            sy = fixed_quotient(a1 * c2 - a2 * c1, det, e.cy);
            e.status = (sx || sy) ? ST_SAT : ST_FOUND;
        end
        return e;
    endfunction

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 15)) - 16'd8;
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_pair(logic [15:0] v[8]);
        logic [127:0] d;
        for (int i = 0; i < 8; i++) d[i*16 +: 16] = v[i];
        pending_pairs.push_back(d);
    endtask

    // driver: advance on accept, idle at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata <= pending_pairs[0];
                    expected_points.push_back(predict_crossing(pending_pairs.pop_front()));
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // monitor
    always @(posedge aclk) begin
        cross_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h/%h", m_tuser, m_tdata);
            end else begin
                e = expected_points.pop_front();
                if (m_tuser !== e.status || m_tdata[47:0] !== e.cx
                        || m_tdata[95:48] !== e.cy) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp st=%0d x=%h y=%h got st=%0d x=%h y=%h",
                                 e.status, e.cx, e.cy, m_tuser, m_tdata[47:0],
                                 m_tdata[95:48]);
                end
            end
        end
    end

    initial begin
        logic [15:0] v[8];
        int          idle_phase[4] = '{0, 60, 0, 34};
        int          stall_phase[4] = '{0, 0, 60, 34};
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        // directed: extremes, parallel, degenerate, saturation, simple crossings
        v = '{16'h0, 16'h0, 16'd2, 16'd2, 16'h0, 16'd2, 16'd2, 16'h0}; add_pair(v);
        v = '{16'h0, 16'h0, 16'd1, 16'd1, 16'd1, 16'h0, 16'd2, 16'd1}; add_pair(v);
        v = '{16'd5, 16'd5, 16'd5, 16'd5, 16'h0, 16'h0, 16'd1, 16'd3}; add_pair(v);
        v = '{16'h0, 16'h0, 16'd1, 16'd1, 16'h0, 16'h0, 16'd1, 16'd1}; add_pair(v);
        v = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
              16'h7fff, 16'h8000}; add_pair(v);
        v = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8001,
              16'h7fff, 16'h7fff}; add_pair(v);
        v = '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h7fff, 16'h7ffe}; add_pair(v);
        v = '{16'h0, 16'h0, 16'd3, 16'h0, 16'h0, 16'd1, 16'd3, 16'd2}; add_pair(v);
        v = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
              16'hffff, 16'hffff}; add_pair(v);
        v = '{16'h0, 16'h0, 16'd3, 16'd1, 16'h0, 16'd1, 16'd3, 16'd0}; add_pair(v);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_phase[ph];
            recv_stall_pct = stall_phase[ph];
            for (int n = 0; n < 375; n++) begin
                int mode;
                mode = $urandom_range(0, 5);
                for (int i = 0; i < 8; i++)
                    v[i] = rand_coord(mode < 2 ? 0 : (mode == 2 ? $urandom_range(0, 2) : 2));
                // near-parallel second line drives large quotients
                if (mode == 3) begin
                    v[4] = v[0] + 16'($urandom_range(0, 3));
                    v[5] = v[1];
                    v[6] = v[2];
                    v[7] = v[3] + 16'($urandom_range(0, 1));
                end
                add_pair(v);
            end
            while (pending_pairs.size() > 0) @(posedge aclk);
        end
        while (pending_pairs.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/lip_pkg.sv
src/lip_front.sv
src/lip_div_cell.sv
src/line_intersection_point.sv
src/lip_checker.sv
sim/testbench.sv
